[design/smic_pkg.sv]
package smic_pkg;

    localparam int ENT_W  = 32;
    localparam int N_ENT  = 9;
    localparam int ADJ_W  = 65;
    localparam int DET_W  = 98;
    localparam int DM_W   = 97;
    localparam int NUM_W  = 64;
    localparam int QUO_W  = 32;
    localparam int SUM_W  = 68;
    localparam int ROOT_W = 34;
    localparam int IN_W   = N_ENT * ENT_W;
    localparam int OUT_W  = N_ENT * ENT_W + 32;
    localparam int USER_W = 2;

    localparam logic signed [ENT_W-1:0] INV_MAX = 32'sh7fff_ffff;
    localparam logic signed [ENT_W-1:0] INV_MIN = 32'sh8000_0000;
    localparam logic [31:0]             COND_MAX = 32'hffff_ffff;

    typedef struct packed {
        logic neg;
        logic big;
    } lane_flags_t;

endpackage

[design/smic_delay.sv]
module smic_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         adv,
    input  logic [W-1:0] d_i,
    output logic [W-1:0] d_o
);

    logic [W-1:0] dly_reg [N];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_reg[0] <= d_i;
            for (int i = 1; i < N; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign d_o = dly_reg[N-1];

endmodule

[design/smic_div_lane.sv]
module smic_div_lane (
    input  logic                       aclk,
    input  logic                       adv,
    input  logic [smic_pkg::NUM_W-1:0] num_i,
    input  logic [smic_pkg::DM_W-1:0]  dm_i,
    input  smic_pkg::lane_flags_t      flags_i,
    output logic [smic_pkg::QUO_W-1:0] q_o,
    output smic_pkg::lane_flags_t      flags_o
);

    localparam int STEPS = smic_pkg::QUO_W;
    localparam int DW    = smic_pkg::DM_W;

    logic [DW-1:0]                rem_reg   [STEPS];
    logic [DW-1:0]                dm_reg    [STEPS];
    logic [smic_pkg::QUO_W-1:0]   q_reg     [STEPS];
    smic_pkg::lane_flags_t        flags_reg [STEPS];

    // Restoring division, one quotient bit per stage. The remainder starts as the
    // numerator, which is below the divisor whenever the result is in range.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [DW-1:0]              rem_prev;
        logic [DW-1:0]              dm_prev;
        logic [smic_pkg::QUO_W-1:0] q_prev;
        smic_pkg::lane_flags_t      fl_prev;
        logic [DW:0]                t;
        logic                       ge;

        if (g == 0) begin : g_first
            assign rem_prev = DW'(num_i);
            assign dm_prev  = dm_i;
            assign q_prev   = '0;
            assign fl_prev  = flags_i;
        end else begin : g_next
            assign rem_prev = rem_reg[g-1];
            assign dm_prev  = dm_reg[g-1];
            assign q_prev   = q_reg[g-1];
            assign fl_prev  = flags_reg[g-1];
        end

        assign t  = {rem_prev, 1'b0};
        assign ge = t >= {1'b0, dm_prev};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[g]   <= ge ? DW'(t - {1'b0, dm_prev}) : t[DW-1:0];
                dm_reg[g]    <= dm_prev;
                q_reg[g]     <= {q_prev[smic_pkg::QUO_W-2:0], ge};
                flags_reg[g] <= fl_prev;
            end
        end
    end

    assign q_o     = q_reg[STEPS-1];
    assign flags_o = flags_reg[STEPS-1];

endmodule

[design/smic_isqrt.sv]
module smic_isqrt (
    input  logic                        aclk,
    input  logic                        adv,
    input  logic [smic_pkg::SUM_W-1:0]  v_i,
    output logic [smic_pkg::ROOT_W-1:0] root_o
);

    localparam int STEPS = smic_pkg::ROOT_W;
    localparam int RW    = smic_pkg::ROOT_W + 2;
    localparam int VW    = smic_pkg::SUM_W;

    logic [RW-1:0]               rem_reg  [STEPS];
    logic [smic_pkg::ROOT_W-1:0] root_reg [STEPS];
    logic [VW-1:0]               val_reg  [STEPS];

    // Digit-by-digit square root: two radicand bits enter per stage from the top.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [RW-1:0]               rem_prev;
        logic [smic_pkg::ROOT_W-1:0] root_prev;
        logic [VW-1:0]               val_prev;
        logic [RW+1:0]               x;
        logic [RW+1:0]               trial;
        logic                        ge;

        if (g == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = v_i;
        end else begin : g_next
            assign rem_prev  = rem_reg[g-1];
            assign root_prev = root_reg[g-1];
            assign val_prev  = val_reg[g-1];
        end

        assign x     = {rem_prev, val_prev[VW-1 -: 2]};
        assign trial = (RW+2)'({root_prev, 2'b01});
        assign ge    = x >= trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[g]  <= ge ? RW'(x - trial) : x[RW-1:0];
                root_reg[g] <= {root_prev[smic_pkg::ROOT_W-2:0], ge};
                val_reg[g]  <= {val_prev[VW-3:0], 2'b00};
            end
        end
    end

    assign root_o = root_reg[STEPS-1];

endmodule

[design/small_matrix_inverse_condition.sv]
// Inverts one DIM x DIM matrix of signed Q16.16 entries per beat and reports a
// Frobenius condition estimate. The pipeline takes a new matrix every cycle
// unless a finished result is stalled by m_tready. Most of the pipeline depth
// lies in the nine 32-stage divider lanes that form the inverse entries and the
// two 34-stage square root units behind them. A one-beat input skid lets the
// block take one more matrix while a finished result waits on the output. A
// singular matrix gives zero inverse entries, the condition field at its maximum
// and invertible low.
module small_matrix_inverse_condition #(
    parameter int DIM = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each)
    input  logic [smic_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, cond_number
    output logic [smic_pkg::OUT_W-1:0]   m_tdata,
    // invertible, saturated
    output logic [smic_pkg::USER_W-1:0]  m_tuser
);

    localparam int DIMC  = (DIM < 1) ? 1 : ((DIM > 3) ? 3 : DIM);
    localparam int NE    = smic_pkg::N_ENT;
    localparam int EW    = smic_pkg::ENT_W;
    localparam int LAT   = 5 + smic_pkg::QUO_W + 3 + smic_pkg::ROOT_W + 4;
    localparam logic [NE-1:0] USED = (DIMC == 1) ? 9'b000000001 :
                                     (DIMC == 2) ? 9'b000011011 : 9'b111111111;
    localparam logic [34:0] RECIP    = 35'((64'd1 << 34) / DIMC);
    localparam logic [51:0] CSAT_LIM = 52'(DIMC) << 32;
    localparam logic [34:0] DIMV     = 35'(DIMC);
    localparam int META_W = NE * EW + 2;

    function automatic logic signed [smic_pkg::ADJ_W-1:0] cof(
        input logic signed [EW-1:0] w, input logic signed [EW-1:0] x,
        input logic signed [EW-1:0] y, input logic signed [EW-1:0] z);
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        p1 = w * x;
        p2 = y * z;
        cof = smic_pkg::ADJ_W'(p1) - smic_pkg::ADJ_W'(p2);
    endfunction

    // ---------------- input skid and pipeline advance ----------------
    logic                       adv;
    logic                       in_v;
    logic [smic_pkg::IN_W-1:0]  in_data;
    logic                       skid_v_reg, skid_v_next;
    logic [smic_pkg::IN_W-1:0]  skid_data_reg;
    logic [LAT-1:0]             vld_reg;

    assign m_tvalid = vld_reg[LAT-1];
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = !skid_v_reg;
    assign in_v     = skid_v_reg || s_tvalid;
    assign in_data  = skid_v_reg ? skid_data_reg : s_tdata;

    always_comb begin
        skid_v_next = skid_v_reg;
        if (adv) begin
            skid_v_next = 1'b0;
        end else if (!skid_v_reg && s_tvalid) begin
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_v_reg <= 1'b0;
            vld_reg    <= '0;
        end else begin
            skid_v_reg <= skid_v_next;
            if (adv) begin
                vld_reg <= {vld_reg[LAT-2:0], in_v};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && !skid_v_reg && s_tvalid) begin
            skid_data_reg <= s_tdata;
        end
    end

    // ---------------- T0: entries ----------------
    logic signed [EW-1:0] a_reg [NE];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NE; k++) begin
                a_reg[k] <= in_data[k*EW +: EW];
            end
        end
    end

    // ---------------- T1: adjugate, squares ----------------
    logic signed [smic_pkg::ADJ_W-1:0] adj_next [NE];
    logic signed [smic_pkg::ADJ_W-1:0] det_small_next;
    logic signed [63:0]                sqs [NE];
    logic [63:0]                       sq_next [NE];
    logic signed [smic_pkg::ADJ_W-1:0] adj1_reg [NE];
    logic signed [smic_pkg::ADJ_W-1:0] det_small1_reg;
    logic [63:0]                       sq1_reg [NE];
    logic signed [EW-1:0]              row0_reg [3];

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            adj_next[k] = '0;
            sqs[k]      = a_reg[k] * a_reg[k];
            sq_next[k]  = USED[k] ? sqs[k] : 64'd0;
        end
        det_small_next = '0;
        if (DIMC == 1) begin
            adj_next[0]    = 65'sd1;
            det_small_next = smic_pkg::ADJ_W'(a_reg[0]);
        end else if (DIMC == 2) begin
            adj_next[0]    = smic_pkg::ADJ_W'(a_reg[4]);
            adj_next[1]    = -(smic_pkg::ADJ_W'(a_reg[1]));
            adj_next[3]    = -(smic_pkg::ADJ_W'(a_reg[3]));
            adj_next[4]    = smic_pkg::ADJ_W'(a_reg[0]);
            det_small_next = cof(a_reg[0], a_reg[4], a_reg[3], a_reg[1]);
        end else begin
            adj_next[0] = cof(a_reg[4], a_reg[8], a_reg[5], a_reg[7]);
            adj_next[1] = cof(a_reg[2], a_reg[7], a_reg[1], a_reg[8]);
            adj_next[2] = cof(a_reg[1], a_reg[5], a_reg[2], a_reg[4]);
            adj_next[3] = cof(a_reg[5], a_reg[6], a_reg[3], a_reg[8]);
            adj_next[4] = cof(a_reg[0], a_reg[8], a_reg[2], a_reg[6]);
            adj_next[5] = cof(a_reg[2], a_reg[3], a_reg[0], a_reg[5]);
            adj_next[6] = cof(a_reg[3], a_reg[7], a_reg[4], a_reg[6]);
            adj_next[7] = cof(a_reg[1], a_reg[6], a_reg[0], a_reg[7]);
            adj_next[8] = cof(a_reg[0], a_reg[4], a_reg[1], a_reg[3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            adj1_reg       <= adj_next;
            sq1_reg        <= sq_next;
            det_small1_reg <= det_small_next;
            for (int k = 0; k < 3; k++) begin
                row0_reg[k] <= a_reg[k];
            end
        end
    end

    // ---------------- T2: determinant partial products, input energy ----------------
    logic [64:0]                       adj_abs [3];
    logic [32:0]                       a_abs   [3];
    logic [63:0]                       plo_next [3];
    logic [63:0]                       phi_next [3];
    logic [smic_pkg::SUM_W-1:0]        sa_next;
    logic [63:0]                       plo2_reg [3];
    logic [63:0]                       phi2_reg [3];
    logic [2:0]                        psgn2_reg;
    logic signed [smic_pkg::ADJ_W-1:0] adj2_reg [NE];
    logic signed [smic_pkg::ADJ_W-1:0] det_small2_reg;
    logic [smic_pkg::SUM_W-1:0]        sa2_reg;

    always_comb begin
        sa_next = '0;
        for (int k = 0; k < NE; k++) begin
            sa_next = sa_next + smic_pkg::SUM_W'(sq1_reg[k]);
        end
        // First column of the adjugate against the first row of the matrix.
        for (int k = 0; k < 3; k++) begin
            adj_abs[k]  = adj1_reg[3*k][smic_pkg::ADJ_W-1] ? 65'(-adj1_reg[3*k])
                                                           : 65'(adj1_reg[3*k]);
            a_abs[k]    = row0_reg[k][EW-1] ? 33'(-(33'(row0_reg[k])))
                                            : 33'(row0_reg[k]);
            plo_next[k] = adj_abs[k][31:0] * a_abs[k][31:0];
            phi_next[k] = adj_abs[k][63:32] * a_abs[k][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                plo2_reg[k]  <= plo_next[k];
                phi2_reg[k]  <= phi_next[k];
                psgn2_reg[k] <= adj1_reg[3*k][smic_pkg::ADJ_W-1] ^ row0_reg[k][EW-1];
            end
            adj2_reg       <= adj1_reg;
            det_small2_reg <= det_small1_reg;
            sa2_reg        <= sa_next;
        end
    end

    // ---------------- T3: determinant ----------------
    logic [95:0]                       term [3];
    logic signed [smic_pkg::DET_W-1:0] det_next;
    logic signed [smic_pkg::DET_W-1:0] det3_reg;
    logic signed [smic_pkg::ADJ_W-1:0] adj3_reg [NE];
    logic [smic_pkg::SUM_W-1:0]        sa3_reg;

    always_comb begin
        det_next = '0;
        for (int k = 0; k < 3; k++) begin
            term[k]  = {phi2_reg[k], 32'd0} + {32'd0, plo2_reg[k]};
            det_next = psgn2_reg[k] ? det_next - smic_pkg::DET_W'(term[k])
                                    : det_next + smic_pkg::DET_W'(term[k]);
        end
        if (DIMC != 3) begin
            det_next = smic_pkg::DET_W'(det_small2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            det3_reg <= det_next;
            adj3_reg <= adj2_reg;
            sa3_reg  <= sa2_reg;
        end
    end

    // ---------------- T4: lane set-up ----------------
    logic [smic_pkg::DET_W-1:0] det_abs;
    logic [smic_pkg::ADJ_W-1:0] num_abs [NE];
    logic [smic_pkg::DM_W-1:0]  dm4_reg;
    logic [smic_pkg::NUM_W-1:0] num4_reg [NE];
    smic_pkg::lane_flags_t      fl4_reg  [NE];
    logic                       sing4_reg;
    logic [smic_pkg::SUM_W-1:0] sa4_reg;

    always_comb begin
        det_abs = det3_reg[smic_pkg::DET_W-1] ? smic_pkg::DET_W'(-det3_reg)
                                              : smic_pkg::DET_W'(det3_reg);
        for (int k = 0; k < NE; k++) begin
            num_abs[k] = adj3_reg[k][smic_pkg::ADJ_W-1] ? smic_pkg::ADJ_W'(-adj3_reg[k])
                                                        : smic_pkg::ADJ_W'(adj3_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dm4_reg   <= det_abs[smic_pkg::DM_W-1:0];
            sing4_reg <= (det3_reg == '0);
            sa4_reg   <= sa3_reg;
            for (int k = 0; k < NE; k++) begin
                num4_reg[k]    <= num_abs[k][smic_pkg::NUM_W-1:0];
                fl4_reg[k].neg <= adj3_reg[k][smic_pkg::ADJ_W-1]
                                  ^ det3_reg[smic_pkg::DET_W-1];
                // A quotient of 2^32 or more is out of range in either sign.
                fl4_reg[k].big <= {33'd0, num_abs[k][smic_pkg::NUM_W-1:0]}
                                  >= det_abs[smic_pkg::DM_W-1:0];
            end
        end
    end

    // ---------------- divider lanes ----------------
    logic [smic_pkg::QUO_W-1:0] q_lane  [NE];
    smic_pkg::lane_flags_t      fl_lane [NE];

    for (genvar g = 0; g < NE; g++) begin : g_lane
        smic_div_lane u_lane (
            .aclk    (aclk),
            .adv     (adv),
            .num_i   (num4_reg[g]),
            .dm_i    (dm4_reg),
            .flags_i (fl4_reg[g]),
            .q_o     (q_lane[g]),
            .flags_o (fl_lane[g])
        );
    end

    logic                       sing_d;
    logic [smic_pkg::SUM_W-1:0] sa_d;

    smic_delay #(.W(1), .N(smic_pkg::QUO_W)) u_sing_dly (
        .aclk (aclk), .adv (adv), .d_i (sing4_reg), .d_o (sing_d)
    );

    smic_delay #(.W(smic_pkg::SUM_W), .N(smic_pkg::QUO_W + 3)) u_sa_dly (
        .aclk (aclk), .adv (adv), .d_i (sa4_reg), .d_o (sa_d)
    );

    // ---------------- D1: clip to Q16.16 ----------------
    logic signed [EW-1:0] inv_next [NE];
    logic [NE-1:0]        satl_next;
    logic signed [EW-1:0] inv1_reg [NE];
    logic [NE-1:0]        satl1_reg;
    logic                 sing_d1_reg;

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            satl_next[k] = 1'b0;
            if (fl_lane[k].big) begin
                satl_next[k] = 1'b1;
                inv_next[k]  = fl_lane[k].neg ? smic_pkg::INV_MIN : smic_pkg::INV_MAX;
            end else if (fl_lane[k].neg) begin
                if (q_lane[k] > 32'h8000_0000) begin
                    satl_next[k] = 1'b1;
                    inv_next[k]  = smic_pkg::INV_MIN;
                end else begin
                    inv_next[k] = EW'(32'd0 - q_lane[k]);
                end
            end else begin
                if (q_lane[k][31]) begin
                    satl_next[k] = 1'b1;
                    inv_next[k]  = smic_pkg::INV_MAX;
                end else begin
                    inv_next[k] = q_lane[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            inv1_reg    <= inv_next;
            satl1_reg   <= satl_next;
            sing_d1_reg <= sing_d;
        end
    end

    // ---------------- D2: inverse squares ----------------
    logic signed [63:0]   sqi_s [NE];
    logic [63:0]          sqi2_reg [NE];
    logic signed [EW-1:0] inv2_reg [NE];
    logic                 sat2_reg;
    logic                 sing_d2_reg;

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            sqi_s[k] = inv1_reg[k] * inv1_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NE; k++) begin
                sqi2_reg[k] <= sqi_s[k];
            end
            inv2_reg    <= inv1_reg;
            sat2_reg    <= |satl1_reg;
            sing_d2_reg <= sing_d1_reg;
        end
    end

    // ---------------- D3: inverse energy ----------------
    logic [smic_pkg::SUM_W-1:0] si_next;
    logic [smic_pkg::SUM_W-1:0] si3_reg;
    logic [META_W-1:0]          meta3_reg;

    always_comb begin
        si_next = '0;
        for (int k = 0; k < NE; k++) begin
            si_next = si_next + smic_pkg::SUM_W'(sqi2_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            si3_reg <= si_next;
            for (int k = 0; k < NE; k++) begin
                meta3_reg[k*EW +: EW] <= inv2_reg[k];
            end
            meta3_reg[META_W-2] <= sat2_reg;
            meta3_reg[META_W-1] <= sing_d2_reg;
        end
    end

    // ---------------- square roots ----------------
    logic [smic_pkg::ROOT_W-1:0] na_root, ni_root;
    logic [META_W-1:0]           meta_d;

    smic_isqrt u_sqrt_a (.aclk (aclk), .adv (adv), .v_i (sa_d),    .root_o (na_root));
    smic_isqrt u_sqrt_i (.aclk (aclk), .adv (adv), .v_i (si3_reg), .root_o (ni_root));

    smic_delay #(.W(META_W), .N(smic_pkg::ROOT_W + 3)) u_meta_dly (
        .aclk (aclk), .adv (adv), .d_i (meta3_reg), .d_o (meta_d)
    );

    // ---------------- M1..M3: norm product and scaling by 1/DIM ----------------
    logic [65:0] plo_m1_reg;
    logic [35:0] phi_m1_reg;
    logic [67:0] p_m2;
    logic [33:0] xr_m2_reg;
    logic        csat_m2_reg;
    logic [68:0] qprod;
    logic [33:0] q0_m3_reg;
    logic [33:0] xr_m3_reg;
    logic        csat_m3_reg;

    assign p_m2  = 68'(plo_m1_reg) + {phi_m1_reg[35:0], 32'd0};
    assign qprod = xr_m2_reg * RECIP;

    always_ff @(posedge aclk) begin
        if (adv) begin
            plo_m1_reg  <= na_root * ni_root[31:0];
            phi_m1_reg  <= na_root * ni_root[33:32];
            xr_m2_reg   <= p_m2[49:16];
            csat_m2_reg <= p_m2[67:16] >= CSAT_LIM;
            q0_m3_reg   <= qprod[67:34];
            xr_m3_reg   <= xr_m2_reg;
            csat_m3_reg <= csat_m2_reg;
        end
    end

    // ---------------- M4: correction and output register ----------------
    logic [34:0]                  rem_m4;
    logic [33:0]                  q_m4;
    logic [31:0]                  cond_m4;
    logic                         sing_m4;
    logic [smic_pkg::OUT_W-1:0]   out_data_next;
    logic [smic_pkg::USER_W-1:0]  out_user_next;
    logic [smic_pkg::OUT_W-1:0]   out_data_reg;
    logic [smic_pkg::USER_W-1:0]  out_user_reg;

    // The reciprocal estimate is at most one short of the true quotient.
    always_comb begin
        rem_m4  = {1'b0, xr_m3_reg} - 35'(DIMV * {1'b0, q0_m3_reg});
        q_m4    = (rem_m4 >= DIMV) ? q0_m3_reg + 34'd1 : q0_m3_reg;
        cond_m4 = csat_m3_reg ? smic_pkg::COND_MAX : q_m4[31:0];
        sing_m4 = meta_d[META_W-1];
        if (sing_m4) begin
            out_data_next = {smic_pkg::COND_MAX, {(NE*EW){1'b0}}};
            out_user_next = 2'b00;
        end else begin
            out_data_next = {cond_m4, meta_d[NE*EW-1:0]};
            out_user_next = {meta_d[META_W-2] | csat_m3_reg, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    // ---------------- assertions ----------------
    a_singular: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1] && m_tdata[319:288] == 32'hffff_ffff
                                    && m_tdata[287:0] == '0)
        else $error("singular result carries inverse data or saturation");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(!adv))
        else $error("skid filled while the pipeline was advancing");

    a_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_v |=> vld_reg[0])
        else $error("taken beat did not enter the pipeline");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule
